>>> rtl/cst_pkg.sv
package cst_pkg;

   localparam int DEF_BUCKETS = 256;
   localparam int DEF_WAYS    = 4;

   localparam int KEY_W  = 64;
   localparam int CONN_W = 32;
   localparam int HND_W  = 64;
   localparam int FLAG_W = 4;
   localparam int CNT_W  = 16;

   typedef enum logic [2:0] {
      OP_SET_CONN      = 3'd0,
      OP_SET_HANDLER   = 3'd1,
      OP_REMOVE        = 3'd2,
      OP_RELEASE_CONN  = 3'd3,
      OP_REF_DECREMENT = 3'd4,
      OP_PENDING_INC   = 3'd5,
      OP_LOOKUP        = 3'd6,
      OP_REF_INC       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_MISSING  = 3'd3,
      ST_FULL     = 3'd4,
      ST_KEPT     = 3'd5
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    conn_id;
      logic [CONN_W-1:0]   conn_handle;
      logic [HND_W-1:0]    handler_handle;
      logic                want_empty;
      logic                want_close;
      logic                want_shut;
      logic                want_msg;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                hit;
      logic [CONN_W-1:0]   conn_out;
      logic [HND_W-1:0]    handler_out;
      logic signed [CNT_W-1:0] pending_out;
      logic [CNT_W-1:0]    refs_out;
      logic [FLAG_W-1:0]   flags_out;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [CONN_W-1:0]   conn;
      logic [HND_W-1:0]    handler;
      logic [FLAG_W-1:0]   flags;
      logic signed [CNT_W-1:0] pending;
      logic [CNT_W-1:0]    refs;
   } way_type;

   localparam int WAY_W = $bits(way_type);

endpackage

>>> rtl/cst_bucket.sv
module cst_bucket #(
   parameter int BUCKETS = cst_pkg::DEF_BUCKETS,
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cst_pkg::KEY_W-1:0]  key,
   output logic                       done,
   output logic [BW-1:0]              bucket
);

   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   // weight of key byte k in the remainder: 2^(8k) modulo BUCKETS
   function automatic logic [BW-1:0] byte_weight(int k);
      int r;
      r = 1 % BUCKETS;
      for (int i = 0; i < 8 * k; i++) begin
         r = (r * 2) % BUCKETS;
      end
      return BW'(r);
   endfunction

   generate
      if (POW2) begin : g_mask
         logic          done_ff;
         logic [BW-1:0] bucket_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               bucket_ff <= key[BW-1:0] & BW'(BUCKETS - 1);
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_recip
         // fold the key bytes with their weights into a short sum, then
         // reduce it by a reciprocal multiply and one multiply-subtract
         localparam int XW = BW + 11;
         localparam int MW = XW + 1;
         localparam int PW = XW + MW;
         localparam int QW = XW - BW + 1;
         localparam int SH = XW + BW;
         localparam logic [63:0] RECIP =
            ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
         localparam logic [BW-1:0] WGT [8] = '{
            byte_weight(0), byte_weight(1), byte_weight(2), byte_weight(3),
            byte_weight(4), byte_weight(5), byte_weight(6), byte_weight(7)
         };

         logic          v1_ff;
         logic          v2_ff;
         logic          done_ff;
         logic [XW-1:0] x1_ff;
         logic [XW-1:0] x2_ff;
         logic [QW-1:0] q_ff;
         logic [BW-1:0] bucket_ff;
         logic [XW-1:0] fold;
         logic [PW-1:0] prod;
         logic [XW-1:0] qb;
         logic [XW-1:0] rem;

         always_comb begin
            fold = '0;
            for (int k = 0; k < 8; k++) begin
               fold = fold + XW'(key[8*k +: 8]) * XW'(WGT[k]);
            end
            prod = PW'(x1_ff) * PW'(RECIP[MW-1:0]);
            qb   = XW'(q_ff) * XW'(BUCKETS);
            rem  = x2_ff - qb;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff   <= 1'b0;
               v2_ff   <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               v1_ff   <= start;
               v2_ff   <= v1_ff;
               done_ff <= v2_ff;
            end
            if (start) begin
               x1_ff <= fold;
            end
            if (v1_ff) begin
               x2_ff <= x1_ff;
               q_ff  <= prod[SH +: QW];
            end
            if (v2_ff) begin
               bucket_ff <= rem[BW-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end
   endgenerate

endmodule

>>> rtl/cst_row_ram.sv
module cst_row_ram #(
   parameter int DEPTH = cst_pkg::DEF_BUCKETS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DW    = cst_pkg::DEF_WAYS * cst_pkg::WAY_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cst_update.sv
module cst_update #(
   parameter int WAYS = cst_pkg::DEF_WAYS
) (
   input  cst_pkg::req_type                 req,
   input  cst_pkg::way_type [WAYS-1:0]      row,
   output cst_pkg::way_type [WAYS-1:0]      row_new,
   output cst_pkg::rsp_type                 rsp
);

   localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic             hit_found;
   logic             free_found;
   logic [WIW-1:0]   hit_idx;
   logic [WIW-1:0]   free_idx;
   cst_pkg::way_type e;

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (row[w].valid) begin
            if (!hit_found && row[w].key == req.conn_id) begin
               hit_found = 1'b1;
               hit_idx   = WIW'(w);
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_idx   = WIW'(w);
         end
      end

      row_new         = row;
      rsp.status      = cst_pkg::ST_MISSING;
      rsp.hit         = 1'b0;
      rsp.conn_out    = '0;
      rsp.handler_out = '0;
      rsp.pending_out = '1;
      rsp.refs_out    = '0;
      rsp.flags_out   = '0;
      e               = row[hit_idx];

      if (!hit_found) begin
         if (req.op == cst_pkg::OP_SET_CONN || req.op == cst_pkg::OP_SET_HANDLER) begin
            if (!free_found) begin
               rsp.status = cst_pkg::ST_FULL;
            end else begin
               // insert into the lowest free way
               e.valid   = 1'b1;
               e.key     = req.conn_id;
               e.pending = '0;
               e.refs    = cst_pkg::CNT_W'(1);
               if (req.op == cst_pkg::OP_SET_CONN) begin
                  e.conn    = req.conn_handle;
                  e.handler = '0;
                  e.flags   = '0;
               end else begin
                  e.conn    = '0;
                  e.handler = req.handler_handle;
                  e.flags   = {req.want_msg, req.want_shut, req.want_close, req.want_empty};
               end
               row_new[free_idx] = e;
               rsp.status        = cst_pkg::ST_INSERTED;
               rsp.conn_out      = e.conn;
               rsp.handler_out   = e.handler;
               rsp.pending_out   = e.pending;
               rsp.refs_out      = e.refs;
               rsp.flags_out     = e.flags;
            end
         end
      end else begin
         rsp.status = cst_pkg::ST_UPDATED;
         unique case (req.op) inside
            cst_pkg::OP_SET_CONN: begin
               e.conn = req.conn_handle;
            end
            cst_pkg::OP_SET_HANDLER: begin
               e.handler = req.handler_handle;
            end
            cst_pkg::OP_REMOVE: begin
               e.valid    = 1'b0;
               rsp.status = cst_pkg::ST_REMOVED;
            end
            cst_pkg::OP_RELEASE_CONN, cst_pkg::OP_REF_DECREMENT: begin
               if (e.refs <= cst_pkg::CNT_W'(1)) begin
                  e.refs     = '0;
                  e.valid    = 1'b0;
                  rsp.status = cst_pkg::ST_REMOVED;
               end else begin
                  e.refs = e.refs - cst_pkg::CNT_W'(1);
                  if (req.op == cst_pkg::OP_RELEASE_CONN) begin
                     e.pending = '1;
                  end
                  rsp.status = cst_pkg::ST_KEPT;
               end
            end
            cst_pkg::OP_PENDING_INC: begin
               if (e.pending != {1'b0, {(cst_pkg::CNT_W-1){1'b1}}}) begin
                  e.pending = e.pending + cst_pkg::CNT_W'(1);
               end
            end
            cst_pkg::OP_LOOKUP: begin
            end
            cst_pkg::OP_REF_INC: begin
               if (e.refs != '1) begin
                  e.refs = e.refs + cst_pkg::CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
         row_new[hit_idx] = e;
         rsp.hit          = 1'b1;
         rsp.conn_out     = e.conn;
         rsp.handler_out  = e.handler;
         rsp.pending_out  = e.pending;
         rsp.refs_out     = e.refs;
         rsp.flags_out    = e.flags;
      end
   end

endmodule

>>> rtl/connection_slot_table.sv
// Connection slot table: a hashed table of connection slots keyed by a 64-bit id.
// Each transaction on req_ runs one operation (set, remove, release, reference
// count or pending updates, lookup) and returns exactly one rsp_ transaction
// describing the slot. A bucket is the key modulo BUCKETS and holds WAYS slots,
// all kept in one row of a single-port-read memory. A transaction takes an
// accept step, a memory read step and a compare/update/write-back step. When
// BUCKETS is a power of two the bucket is latched at the accept edge; else
// it comes from a registered reciprocal reduction (fold sum, quotient,
// remainder) ahead of the memory read. A result waiting in the output
// register holds the block in the write-back step until it is taken. Only one
// transaction is in flight, so a new one is taken only once the last result
// is loaded, and read and write of the same row never overlap. After reset
// the block clears every row, one per cycle, with req_ready low meanwhile.
module connection_slot_table #(
   parameter int BUCKETS = cst_pkg::DEF_BUCKETS,
   parameter int WAYS    = cst_pkg::DEF_WAYS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_payload
);

   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ROW_W = WAYS * cst_pkg::WAY_W;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_CALC  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [BW-1:0]    clr_ff;
   cst_pkg::req_type req_ff;
   logic             rsp_valid_ff;
   cst_pkg::rsp_type rsp_ff;

   logic                        accept;
   logic                        hash_done;
   logic [BW-1:0]               bucket;
   logic [BW-1:0]               row_addr_ff;
   logic                        wr_en;
   logic [BW-1:0]               wr_addr;
   logic [ROW_W-1:0]            wr_data;
   logic [ROW_W-1:0]            rd_data;
   cst_pkg::way_type [WAYS-1:0] row_new;
   cst_pkg::rsp_type            upd_rsp;
   logic                        rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // load the result once the output register is free; until then hold in
   // S_CALC, where the write-back repeats the same row and stays harmless
   assign rsp_load  = (state_ff == S_CALC) && (!rsp_valid_ff || rsp_ready);

   cst_bucket #(.BUCKETS(BUCKETS), .BW(BW)) u_bucket (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .key    (req_payload.conn_id),
      .done   (hash_done),
      .bucket (bucket)
   );

   // clearing pass writes empty rows; otherwise write back the updated row
   always_comb begin
      wr_en   = (state_ff == S_CLEAR) || (state_ff == S_CALC);
      wr_addr = (state_ff == S_CLEAR) ? clr_ff : row_addr_ff;
      wr_data = (state_ff == S_CLEAR) ? '0 : row_new;
   end

   cst_row_ram #(.DEPTH(BUCKETS), .AW(BW), .DW(ROW_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   ((state_ff == S_HASH) && hash_done),
      .rd_addr (bucket),
      .rd_data (rd_data)
   );

   cst_update #(.WAYS(WAYS)) u_update (
      .req     (req_ff),
      .row     (rd_data),
      .row_new (row_new),
      .rsp     (upd_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + BW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         req_ff <= req_payload;
      end
      if ((state_ff == S_HASH) && hash_done) begin
         row_addr_ff <= bucket;
      end
      if (rsp_load) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> tb/connection_slot_table_test.sv
`timescale 1ns / 1ps

module connection_slot_table_test;

   localparam int N_BUCKETS = cst_pkg::DEF_BUCKETS;
   localparam int N_WAYS    = cst_pkg::DEF_WAYS;
   localparam int N_SLOTS   = N_BUCKETS * N_WAYS;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 40000;

   // Slot table model, same layout as the block's bucket rows.
   class slot_scoreboard;
      bit                               live    [N_SLOTS];
      logic [cst_pkg::KEY_W-1:0]        key     [N_SLOTS];
      logic [cst_pkg::CONN_W-1:0]       conn    [N_SLOTS];
      logic [cst_pkg::HND_W-1:0]        handler [N_SLOTS];
      logic [cst_pkg::FLAG_W-1:0]       flags   [N_SLOTS];
      logic signed [cst_pkg::CNT_W-1:0] pending [N_SLOTS];
      logic [cst_pkg::CNT_W-1:0]        refs    [N_SLOTS];
      cst_pkg::rsp_type                 due_q[$];
      int                               mismatches;
      int                               checked;
      int                               status_seen [8];

      function void clear_table();
         foreach (live[i]) live[i] = 0;
      endfunction

      function cst_pkg::rsp_type slot_view(cst_pkg::status_type st, logic h, int e);
         cst_pkg::rsp_type r;
         r.status = st;
         r.hit    = h;
         if (e < 0) begin
            r.conn_out = '0; r.handler_out = '0; r.pending_out = -16'sd1;
            r.refs_out = '0; r.flags_out = '0;
         end else begin
            r.conn_out = conn[e]; r.handler_out = handler[e];
            r.pending_out = pending[e]; r.refs_out = refs[e];
            r.flags_out = flags[e];
         end
         return r;
      endfunction

      // Apply one accepted transaction to the table and queue its result.
      function void note_request(cst_pkg::req_type q);
         int base;
         int found;
         int spare;
         logic [cst_pkg::CNT_W-1:0] old_refs;
         cst_pkg::rsp_type r;
         base  = int'(q.conn_id % N_BUCKETS) * N_WAYS;
         found = -1;
         spare = -1;
         for (int w = 0; w < N_WAYS; w++) begin
            if (live[base + w]) begin
               if (found < 0 && key[base + w] == q.conn_id) found = base + w;
            end else if (spare < 0) begin
               spare = base + w;
            end
         end
         if (found < 0) begin
            if (q.op == cst_pkg::OP_SET_CONN || q.op == cst_pkg::OP_SET_HANDLER) begin
               if (spare < 0) begin
                  r = slot_view(cst_pkg::ST_FULL, 1'b0, -1);
               end else begin
                  live[spare] = 1;
                  key[spare]  = q.conn_id;
                  conn[spare] = (q.op == cst_pkg::OP_SET_CONN) ? q.conn_handle : '0;
                  handler[spare] = (q.op == cst_pkg::OP_SET_CONN) ? '0 : q.handler_handle;
                  flags[spare] = (q.op == cst_pkg::OP_SET_CONN) ? 4'h0 :
                     {q.want_msg, q.want_shut, q.want_close, q.want_empty};
                  pending[spare] = '0;
                  refs[spare] = cst_pkg::CNT_W'(1);
                  r = slot_view(cst_pkg::ST_INSERTED, 1'b0, spare);
               end
            end else begin
               r = slot_view(cst_pkg::ST_MISSING, 1'b0, -1);
            end
         end else begin
            case (q.op)
               cst_pkg::OP_SET_CONN: begin
                  conn[found] = q.conn_handle;
                  r = slot_view(cst_pkg::ST_UPDATED, 1'b1, found);
               end
               cst_pkg::OP_SET_HANDLER: begin
                  handler[found] = q.handler_handle;
                  r = slot_view(cst_pkg::ST_UPDATED, 1'b1, found);
               end
               cst_pkg::OP_REMOVE: begin
                  live[found] = 0;
                  r = slot_view(cst_pkg::ST_REMOVED, 1'b1, found);
               end
               cst_pkg::OP_RELEASE_CONN, cst_pkg::OP_REF_DECREMENT: begin
                  old_refs = refs[found];
                  refs[found] = (old_refs > '0) ? old_refs - cst_pkg::CNT_W'(1) : '0;
                  if (old_refs <= cst_pkg::CNT_W'(1)) begin
                     live[found] = 0;
                     r = slot_view(cst_pkg::ST_REMOVED, 1'b1, found);
                  end else begin
                     if (q.op == cst_pkg::OP_RELEASE_CONN) pending[found] = -16'sd1;
                     r = slot_view(cst_pkg::ST_KEPT, 1'b1, found);
                  end
               end
               cst_pkg::OP_PENDING_INC: begin
                  if (pending[found] < 16'sh7fff) pending[found] = pending[found] + 16'sd1;
                  r = slot_view(cst_pkg::ST_UPDATED, 1'b1, found);
               end
               cst_pkg::OP_LOOKUP: r = slot_view(cst_pkg::ST_UPDATED, 1'b1, found);
               default: begin
                  if (refs[found] != 16'hffff) refs[found] = refs[found] + cst_pkg::CNT_W'(1);
                  r = slot_view(cst_pkg::ST_UPDATED, 1'b1, found);
               end
            endcase
         end
         due_q.push_back(r);
      endfunction

      function void check_response(cst_pkg::rsp_type got);
         cst_pkg::rsp_type want;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = due_q.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp st=%0d hit=%b conn=%h hnd=%h pend=%0d refs=%0d fl=%h",
                        want.status, want.hit, want.conn_out, want.handler_out,
                        want.pending_out, want.refs_out, want.flags_out,
                        "\n          got st=%0d hit=%b conn=%h hnd=%h pend=%0d refs=%0d fl=%h",
                        got.status, got.hit, got.conn_out, got.handler_out,
                        got.pending_out, got.refs_out, got.flags_out);
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   cst_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   cst_pkg::rsp_type rsp_payload;

   slot_scoreboard board = new();
   int  cycles = 0;
   bit  no_idle = 0;        // long stretch with no idling on either side
   int  hold_off = 0;       // receiver stall length, counted by the receiver
   bit  stalled_once = 0;
   logic [cst_pkg::KEY_W-1:0] key_pool [16];

   connection_slot_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   // Note requests and check responses at the edge where they are accepted.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready) board.note_request(req_payload);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_payload);
   end

   // Receiver: random stalls, plus one long hold-off midway through the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else if (!stalled_once && board.checked >= 500) begin
         rsp_ready <= 0;
         hold_off <= 300;   // requests keep coming meanwhile
         stalled_once <= 1;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 21);
      end
   end

   // Offer one transaction and hold it until the block takes it.
   task automatic send(cst_pkg::req_type q);
      while (!no_idle && $urandom_range(99) < 21) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid   <= 1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic cst_pkg::req_type make_req(cst_pkg::op_type op,
                                                 logic [cst_pkg::KEY_W-1:0] id);
      cst_pkg::req_type q;
      q.op = op;
      q.conn_id = id;
      q.conn_handle = $urandom;
      q.handler_handle = {$urandom, $urandom};
      {q.want_empty, q.want_close, q.want_shut, q.want_msg} = 4'($urandom);
      return q;
   endfunction

   // Keys mostly from a small pool crowded into few buckets, so that slots
   // are hit, filled up and collide; the rest fully random.
   function automatic logic [cst_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(9) < 8) return key_pool[$urandom_range(15)];
      return {$urandom, $urandom};
   endfunction

   task automatic run_directed();
      cst_pkg::req_type q;
      logic [cst_pkg::KEY_W-1:0] k;
      k = 64'hffff_ffff_ffff_ff00;   // bucket 0, all high key bits set
      q = make_req(cst_pkg::OP_SET_CONN, k); q.conn_handle = '1; send(q);
      q = make_req(cst_pkg::OP_SET_HANDLER, k); q.handler_handle = '1; send(q);
      send(make_req(cst_pkg::OP_LOOKUP, k));
      send(make_req(cst_pkg::OP_REF_INC, k));
      send(make_req(cst_pkg::OP_RELEASE_CONN, k));   // kept, pending closes
      send(make_req(cst_pkg::OP_PENDING_INC, k));    // closing rises to zero
      send(make_req(cst_pkg::OP_REF_DECREMENT, k));  // last reference removes
      send(make_req(cst_pkg::OP_LOOKUP, k));         // now missing
      // Fill bucket zero, then overflow it.
      for (int w = 0; w <= N_WAYS; w++) begin
         q = make_req(cst_pkg::OP_SET_HANDLER, 64'(w * N_BUCKETS));
         q.handler_handle = '0;
         {q.want_empty, q.want_close, q.want_shut, q.want_msg} = 4'hf;
         send(q);
      end
      send(make_req(cst_pkg::OP_REMOVE, 64'(N_BUCKETS)));   // free way 1
      q = make_req(cst_pkg::OP_SET_CONN, 64'd0); q.conn_handle = '0; send(q);
      send(make_req(cst_pkg::OP_SET_CONN, 64'(7 * N_BUCKETS))); // reuses the hole
      // Ops on a missing key.
      for (int o = 2; o < 8; o++)
         send(make_req(cst_pkg::op_type'(o), 64'h1234_5678_9abc_def1));
      send(make_req(cst_pkg::OP_RELEASE_CONN, 64'd0));
   endtask

   task automatic run_random(int count);
      cst_pkg::req_type q;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n == 150) begin
            no_idle = 1;
         end else if (n == 300) begin
            no_idle = 0;
         end
         pick = $urandom_range(99);
         if (pick < 25) begin
            q = make_req($urandom_range(1) ? cst_pkg::OP_SET_CONN : cst_pkg::OP_SET_HANDLER,
                         pick_key());
         end else if (pick < 40) begin
            q = make_req(cst_pkg::OP_REF_INC, pick_key());
         end else begin
            q = make_req(cst_pkg::op_type'($urandom_range(7)), pick_key());
         end
         send(q);
      end
   endtask

   initial begin
      foreach (key_pool[i])
         key_pool[i] = {$urandom, 16'($urandom), 8'($urandom_range(3)), 8'(i / 4)};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      run_directed();
      run_random(RANDOM_ITEMS);
      req_valid <= 0;
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("checked %0d responses: %0d inserted, %0d removed, %0d kept,",
               board.checked, board.status_seen[cst_pkg::ST_INSERTED],
               board.status_seen[cst_pkg::ST_REMOVED], board.status_seen[cst_pkg::ST_KEPT]);
      $display("%0d bucket full, %0d missing, with one long receiver stall",
               board.status_seen[cst_pkg::ST_FULL], board.status_seen[cst_pkg::ST_MISSING]);
      if (board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("mismatches: %0d", board.mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run guard: covers the clearing pass, all transactions and all stalls.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
